@@ rtl/qclp_pkg.sv @@
`timescale 1ns / 1ps
package qclp_pkg;

    localparam int MAX_NODES  = 8;
    localparam int IDX_W      = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CNT_W      = $clog2(MAX_NODES + 1);
    localparam int CFG_W      = 4;
    localparam int NCMP_W     = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int MODE_W     = 2;
    localparam int NODE_W     = 3;
    localparam int PAGE_W     = 48;
    localparam int OFF_W      = 16;
    localparam int KEY_W      = PAGE_W + OFF_W;
    localparam int CCNT_W     = 4;
    localparam int QUORUM_MAX = MAX_NODES / 2 + 1;
    localparam int SEL_W      = (QUORUM_MAX > 1) ? $clog2(QUORUM_MAX) : 1;

    localparam logic [MODE_W-1:0] MODE_REPORT     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CONNECT    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DISCONNECT = 2'd2;
    localparam logic [MODE_W-1:0] MODE_UNUSED     = 2'd3;

    localparam logic [CFG_W-1:0] NODE_COUNT_RESET = 4'd1;

    typedef logic [KEY_W-1:0] t_key;

    typedef struct packed {
        logic clr;
        logic ins;
    } t_rank_ctl;

endpackage

@@ rtl/qclp_if.sv @@
`timescale 1ns / 1ps
interface qclp_in_if;
    import qclp_pkg::*;

    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   mode;
    logic [NODE_W-1:0]   node_index;
    logic [PAGE_W-1:0]   report_page;
    logic [OFF_W-1:0]    report_offset;

    modport source (output valid, mode, node_index, report_page, report_offset,
                    input ready);
    modport sink (input valid, mode, node_index, report_page, report_offset,
                  output ready);
endinterface

interface qclp_out_if;
    import qclp_pkg::*;

    logic                valid;
    logic                ready;
    logic                accepted;
    logic                position_raised;
    logic                quorum_met;
    logic                consensus_valid;
    logic [PAGE_W-1:0]   consensus_page;
    logic [OFF_W-1:0]    consensus_offset;
    logic [CCNT_W-1:0]   connected_count;

    modport source (output valid, accepted, position_raised, quorum_met, consensus_valid,
                    consensus_page, consensus_offset, connected_count,
                    input ready);
    modport sink (input valid, accepted, position_raised, quorum_met, consensus_valid,
                  consensus_page, consensus_offset, connected_count,
                  output ready);
endinterface

@@ rtl/qclp_pos_ram.sv @@
`timescale 1ns / 1ps
module qclp_pos_ram (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [qclp_pkg::IDX_W-1:0] i_waddr,
    input  qclp_pkg::t_key             i_wdata,
    input  logic [qclp_pkg::IDX_W-1:0] i_raddr,
    output qclp_pkg::t_key             o_rdata
);
    import qclp_pkg::*;

    t_key r_mem [MAX_NODES];
    t_key r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/qclp_rank_sel.sv @@
`timescale 1ns / 1ps
module qclp_rank_sel (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  qclp_pkg::t_rank_ctl        i_ctl,
    input  qclp_pkg::t_key             i_key,
    input  logic [qclp_pkg::SEL_W-1:0] i_sel,
    output qclp_pkg::t_key             o_key,
    output logic                       o_vld
);
    import qclp_pkg::*;

    t_key                  r_key [QUORUM_MAX];
    logic [QUORUM_MAX-1:0] r_vld;
    t_key                  n_key [QUORUM_MAX];
    logic [QUORUM_MAX-1:0] n_vld;
    logic [QUORUM_MAX-1:0] w_gt;

    // keep slots sorted descending; a new key lands above the first smaller or empty slot
    always_comb begin
        for (int k = 0; k < QUORUM_MAX; k++) begin
            w_gt[k] = !r_vld[k] || (i_key > r_key[k]);
        end
        n_key[0] = w_gt[0] ? i_key : r_key[0];
        n_vld[0] = r_vld[0] | w_gt[0];
        for (int k = 1; k < QUORUM_MAX; k++) begin
            if (!w_gt[k]) begin
                n_key[k] = r_key[k];
                n_vld[k] = r_vld[k];
            end else if (!w_gt[k-1]) begin
                n_key[k] = i_key;
                n_vld[k] = 1'b1;
            end else begin
                n_key[k] = r_key[k-1];
                n_vld[k] = r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_ctl.clr) begin
            r_vld <= '0;
        end else if (i_ctl.ins) begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ins) begin
            r_key <= n_key;
        end
    end

    always_comb begin
        o_key = '0;
        o_vld = 1'b0;
        if (int'(i_sel) < QUORUM_MAX) begin
            o_key = r_key[i_sel];
            o_vld = r_vld[i_sel];
        end
    end

endmodule

@@ rtl/quorum_consensus_log_position_top.sv @@
`timescale 1ns / 1ps
// Channel   Direction  Transfer when           Payload
// i_in      in         valid && ready          mode, node_index, report_page, report_offset
// o_out     out        valid && ready          accepted .. connected_count
// cfg       in         i_cfg_we                node_count (i_cfg_wdata)
//
// One event at a time: a new input transfer is taken only after the position memory,
// whose single read port is scanned one node a cycle over the effective node count,
// has been scanned and the result has been loaded into the output register.
// Reset is synchronous, active low; node_count returns to 1, all nodes disconnected
// and unreported. The result waits in an output register while the next event runs.
module quorum_consensus_log_position_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [qclp_pkg::CFG_W-1:0] i_cfg_wdata,
    qclp_in_if.sink                    i_in,
    qclp_out_if.source                 o_out
);
    import qclp_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_UPD  = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]           r_state;
    logic [CFG_W-1:0]     r_ncfg;
    logic [MAX_NODES-1:0] r_conn;
    logic [MAX_NODES-1:0] r_rep;
    logic [NCMP_W-1:0]    r_cnt;
    logic                 r_pend;
    logic [IDX_W-1:0]     r_pidx;
    logic                 r_acc;
    logic                 r_raise;
    logic [MODE_W-1:0]    r_mode;
    logic [IDX_W-1:0]     r_idx;
    t_key                 r_key;

    logic                 r_out_valid;
    logic                 r_out_acc;
    logic                 r_out_raise;
    logic                 r_out_qmet;
    logic                 r_out_cvalid;
    logic [PAGE_W-1:0]    r_out_page;
    logic [OFF_W-1:0]     r_out_off;
    logic [CCNT_W-1:0]    r_out_ccnt;

    logic [NCMP_W-1:0]    w_n;
    logic [NCMP_W-1:0]    w_quorum;
    logic [CNT_W-1:0]     w_ccnt;
    logic                 w_qmet;
    logic                 w_in_xfer;
    logic                 w_out_xfer;
    logic                 w_load;
    logic                 w_acc_in;
    logic                 w_we;
    logic [IDX_W-1:0]     w_raddr;
    t_key                 w_rdata;
    t_rank_ctl            w_rank_ctl;
    t_key                 w_sel_key;
    logic                 w_sel_vld;
    logic                 w_cvalid;

    assign w_n = (NCMP_W'(r_ncfg) > NCMP_W'(MAX_NODES)) ? NCMP_W'(MAX_NODES)
                                                          : NCMP_W'(r_ncfg);
    assign w_quorum = (w_n >> 1) + NCMP_W'(1);

    always_comb begin
        w_ccnt = '0;
        for (int i = 0; i < MAX_NODES; i++) begin
            if (r_conn[i] && (NCMP_W'(i) < w_n)) begin
                w_ccnt = w_ccnt + CNT_W'(1);
            end
        end
    end

    assign w_qmet     = NCMP_W'(w_ccnt) >= w_quorum;
    assign w_in_xfer  = i_in.valid && i_in.ready;
    assign w_out_xfer = r_out_valid && o_out.ready;
    assign w_load     = (r_state == S_OUT) && (!r_out_valid || o_out.ready);
    assign w_acc_in   = (NCMP_W'(i_in.node_index) < w_n) && (i_in.mode != MODE_UNUSED);

    assign w_we = (r_state == S_UPD) && r_acc && (r_mode == MODE_REPORT)
                  && (!r_rep[r_idx] || (r_key > w_rdata));

    assign w_raddr = (r_state == S_IDLE) ? IDX_W'(i_in.node_index) : r_cnt[IDX_W-1:0];

    assign w_rank_ctl.clr = (r_state == S_UPD);
    assign w_rank_ctl.ins = r_pend && r_conn[r_pidx] && r_rep[r_pidx];

    qclp_pos_ram u_pos_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_idx),
        .i_wdata (r_key),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    qclp_rank_sel u_rank_sel (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_rank_ctl),
        .i_key   (w_rdata),
        .i_sel   (SEL_W'(w_n >> 1)),
        .o_key   (w_sel_key),
        .o_vld   (w_sel_vld)
    );

    assign w_cvalid = w_qmet && w_sel_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ncfg      <= NODE_COUNT_RESET;
            r_conn      <= '0;
            r_rep       <= '0;
            r_cnt       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_ncfg <= i_cfg_wdata;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (w_out_xfer) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_xfer) begin
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    if (w_we) begin
                        r_rep[r_idx] <= 1'b1;
                    end
                    if (r_acc && (r_mode == MODE_CONNECT)) begin
                        r_conn[r_idx] <= 1'b1;
                    end
                    if (r_acc && (r_mode == MODE_DISCONNECT)) begin
                        r_conn[r_idx] <= 1'b0;
                    end
                    r_cnt   <= '0;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (r_cnt < w_n) begin
                        r_pend <= 1'b1;
                        r_cnt  <= r_cnt + NCMP_W'(1);
                    end else begin
                        r_pend  <= 1'b0;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_pidx <= r_cnt[IDX_W-1:0];
        if (w_in_xfer) begin
            r_acc  <= w_acc_in;
            r_mode <= i_in.mode;
            r_idx  <= IDX_W'(i_in.node_index);
            r_key  <= {i_in.report_page, i_in.report_offset};
        end
        if (r_state == S_UPD) begin
            r_raise <= w_we;
        end
        if (w_load) begin
            r_out_acc    <= r_acc;
            r_out_raise  <= r_raise;
            r_out_qmet   <= w_qmet;
            r_out_cvalid <= w_cvalid;
            r_out_page   <= w_cvalid ? w_sel_key[KEY_W-1:OFF_W] : '0;
            r_out_off    <= w_cvalid ? w_sel_key[OFF_W-1:0] : '0;
            r_out_ccnt   <= CCNT_W'(w_ccnt);
        end
    end

    assign i_in.ready             = (r_state == S_IDLE);
    assign o_out.valid            = r_out_valid;
    assign o_out.accepted         = r_out_acc;
    assign o_out.position_raised  = r_out_raise;
    assign o_out.quorum_met       = r_out_qmet;
    assign o_out.consensus_valid  = r_out_cvalid;
    assign o_out.consensus_page   = r_out_page;
    assign o_out.consensus_offset = r_out_off;
    assign o_out.connected_count  = r_out_ccnt;

    a_raise_needs_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.position_raised |-> o_out.accepted)
        else $error("position raised on an event that was not applied");

    a_consensus_needs_quorum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.consensus_valid |-> o_out.quorum_met)
        else $error("consensus valid without quorum");

    a_no_consensus_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.consensus_valid
            |-> (o_out.consensus_page == '0) && (o_out.consensus_offset == '0))
        else $error("consensus position not cleared");

    a_write_only_in_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state == S_UPD) && (r_mode == MODE_REPORT) && r_acc)
        else $error("position memory written outside a report update");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_cnt <= w_n))
        else $error("scan counter beyond node count");

endmodule

@@ dv/quorum_consensus_log_position_checker.sv @@
`timescale 1ns / 1ps
module quorum_consensus_log_position_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [qclp_pkg::CFG_W-1:0] i_cfg_wdata,
    qclp_in_if                         i_evt,
    qclp_out_if                        i_res,
    output int                         o_err_count,
    output int                         o_pending
);
    import qclp_pkg::*;

    typedef struct packed {
        logic              accepted;
        logic              raised;
        logic              quorum_met;
        logic              cons_valid;
        logic [PAGE_W-1:0] page;
        logic [OFF_W-1:0]  offset;
        logic [CCNT_W-1:0] conn;
    } t_commit;

    logic [CFG_W-1:0]     node_count;
    logic [MAX_NODES-1:0] link_up;
    logic [MAX_NODES-1:0] has_report;
    t_key                 saved_key [MAX_NODES];
    t_commit              commit_q [$];
    t_commit              want;
    t_commit              got;
    int                   mismatches = 0;

    assign o_err_count = mismatches;

    // unreported nodes rank below every real position
    function automatic logic [KEY_W:0] node_rank(int i);
        return has_report[i] ? {1'b1, saved_key[i]} : '0;
    endfunction

    function automatic t_commit apply_event(logic [MODE_W-1:0] mode,
                                            logic [NODE_W-1:0] idx,
                                            t_key              key);
        t_commit r;
        int n;
        int quorum;
        int cnt;
        int above;
        int at_least;
        bit found;
        r = '0;
        n = (node_count > MAX_NODES) ? MAX_NODES : int'(node_count);
        quorum = n / 2 + 1;
        if (int'(idx) < n) begin
            case (mode)
                MODE_REPORT: begin
                    r.accepted = 1'b1;
                    if (!has_report[idx] || key > saved_key[idx]) begin
                        has_report[idx] = 1'b1;
                        saved_key[idx] = key;
                        r.raised = 1'b1;
                    end
                end
                MODE_CONNECT: begin
                    r.accepted = 1'b1;
                    link_up[idx] = 1'b1;
                end
                MODE_DISCONNECT: begin
                    r.accepted = 1'b1;
                    link_up[idx] = 1'b0;
                end
                default: ;
            endcase
        end
        cnt = 0;
        for (int i = 0; i < n; i++)
            if (link_up[i]) cnt++;
        r.conn = CCNT_W'(cnt);
        if (cnt >= quorum) begin
            r.quorum_met = 1'b1;
            found = 1'b0;
            for (int i = 0; i < n; i++) begin
                if (link_up[i] && !found) begin
                    above = 0;
                    at_least = 0;
                    for (int j = 0; j < n; j++) begin
                        if (link_up[j]) begin
                            if (node_rank(j) > node_rank(i)) above++;
                            if (node_rank(j) >= node_rank(i)) at_least++;
                        end
                    end
                    if (above < quorum && at_least >= quorum) begin
                        found = 1'b1;
                        if (has_report[i]) begin
                            r.cons_valid = 1'b1;
                            {r.page, r.offset} = saved_key[i];
                        end
                    end
                end
            end
        end
        return r;
    endfunction

    task automatic check_field(string name, logic [KEY_W-1:0] want_v, logic [KEY_W-1:0] got_v);
        if (want_v !== got_v) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            node_count = NODE_COUNT_RESET;
            link_up = '0;
            has_report = '0;
            foreach (saved_key[i]) saved_key[i] = '0;
            commit_q.delete();
        end else begin
            if (i_cfg_we) node_count = i_cfg_wdata;
            if (i_evt.valid && i_evt.ready)
                commit_q.push_back(apply_event(i_evt.mode, i_evt.node_index,
                                               {i_evt.report_page, i_evt.report_offset}));
            if (i_res.valid && i_res.ready) begin
                got.accepted   = i_res.accepted;
                got.raised     = i_res.position_raised;
                got.quorum_met = i_res.quorum_met;
                got.cons_valid = i_res.consensus_valid;
                got.page       = i_res.consensus_page;
                got.offset     = i_res.consensus_offset;
                got.conn       = i_res.connected_count;
                if (commit_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result transfer, expected none, actual %p",
                             $time, got);
                end else begin
                    want = commit_q.pop_front();
                    check_field("accepted", KEY_W'(want.accepted), KEY_W'(got.accepted));
                    check_field("position_raised", KEY_W'(want.raised), KEY_W'(got.raised));
                    check_field("quorum_met", KEY_W'(want.quorum_met),
                                KEY_W'(got.quorum_met));
                    check_field("consensus_valid", KEY_W'(want.cons_valid),
                                KEY_W'(got.cons_valid));
                    check_field("consensus_page", KEY_W'(want.page), KEY_W'(got.page));
                    check_field("consensus_offset", KEY_W'(want.offset), KEY_W'(got.offset));
                    check_field("connected_count", KEY_W'(want.conn), KEY_W'(got.conn));
                end
            end
        end
        o_pending = commit_q.size();
    end

endmodule

@@ dv/quorum_consensus_log_position_top_test.sv @@
`timescale 1ns / 1ps
module quorum_consensus_log_position_top_test;
    import qclp_pkg::*;

    localparam int                ITEMS_PER_PHASE = 195;
    localparam int                STALL_LIMIT     = 5000;
    localparam int                DRAIN_CYCLES    = 24;
    localparam int                HOLD_CYCLES     = 300;
    localparam t_key              KEY_MAX         = '1;
    localparam logic [PAGE_W-1:0] PAGE_MAX        = '1;
    localparam logic [OFF_W-1:0]  OFF_MAX         = '1;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;
    int               send_idle_pct;
    int               stall_pct;
    int               hold_len;
    int               idle_cycles = 0;
    int               err_count;
    int               pending;
    int               node_lim;
    t_key             pos_base;
    t_key             last_key [MAX_NODES];
    int               phase_nodes [8] = '{8, 5, 15, 2, 7, 1, 8, 0};

    qclp_in_if  evt_ch();
    qclp_out_if res_ch();

    quorum_consensus_log_position_top u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (evt_ch),
        .o_out       (res_ch)
    );

    quorum_consensus_log_position_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_evt       (evt_ch),
        .i_res       (res_ch),
        .o_err_count (err_count),
        .o_pending   (pending)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // hold off the result side on request, else stall at random
    initial begin
        int hold;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_len != 0) begin
                hold = hold_len;
                hold_len = 0;
                repeat (hold) begin
                    res_ch.ready <= 1'b0;
                    @(posedge clk);
                end
            end
            res_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (evt_ch.valid && evt_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic send_evt(input logic [MODE_W-1:0] m, input logic [NODE_W-1:0] idx,
                            input t_key key);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            evt_ch.valid <= 1'b0;
            @(posedge clk);
        end
        evt_ch.valid         <= 1'b1;
        evt_ch.mode          <= m;
        evt_ch.node_index    <= idx;
        evt_ch.report_page   <= key[KEY_W-1:OFF_W];
        evt_ch.report_offset <= key[OFF_W-1:0];
        do @(posedge clk); while (!evt_ch.ready);
    endtask

    // drain, then write node_count while idle
    task automatic set_nodes(input logic [CFG_W-1:0] v);
        evt_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
        node_lim = (v > MAX_NODES) ? MAX_NODES : int'(v);
    endtask

    task automatic send_random(output bit applied);
        int pick;
        logic [MODE_W-1:0] m;
        logic [NODE_W-1:0] idx;
        t_key key;
        pick = $urandom_range(0, 99);
        if (pick < 60) m = MODE_REPORT;
        else if (pick < 82) m = MODE_CONNECT;
        else if (pick < 95) m = MODE_DISCONNECT;
        else m = MODE_UNUSED;
        if ($urandom_range(0, 99) < 85) idx = NODE_W'($urandom_range(0, node_lim - 1));
        else idx = NODE_W'($urandom_range(0, MAX_NODES - 1));
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            key = pos_base + t_key'($urandom_range(0, 40)) - t_key'(20);
            pos_base += t_key'($urandom_range(0, 8));
        end else if (pick < 80) begin
            key = last_key[idx];
        end else if (pick < 92) begin
            key = {$urandom, $urandom};
        end else begin
            case ($urandom_range(0, 3))
                0: key = '0;
                1: key = KEY_MAX;
                2: key = {PAGE_MAX, OFF_W'(0)};
                default: key = {PAGE_W'(0), OFF_MAX};
            endcase
        end
        if (m == MODE_REPORT) last_key[idx] = key;
        send_evt(m, idx, key);
        applied = (int'(idx) < node_lim) && (m != MODE_UNUSED);
    endtask

    initial begin
        int applied_n;
        bit applied;
        int nodes;
        rst_n                <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_wdata            <= '0;
        evt_ch.valid         <= 1'b0;
        evt_ch.mode          <= MODE_REPORT;
        evt_ch.node_index    <= '0;
        evt_ch.report_page   <= '0;
        evt_ch.report_offset <= '0;
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_len      = 0;
        node_lim      = 1;
        pos_base      = t_key'(1000);
        foreach (last_key[i]) last_key[i] = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_nodes(4'd8);
        send_evt(MODE_REPORT, NODE_W'(0), '0);
        send_evt(MODE_CONNECT, NODE_W'(0), '0);
        send_evt(MODE_CONNECT, NODE_W'(0), '0);
        send_evt(MODE_REPORT, NODE_W'(0), '0);
        send_evt(MODE_REPORT, NODE_W'(1), KEY_MAX);
        for (int i = 1; i < 5; i++) send_evt(MODE_CONNECT, NODE_W'(i), '0);
        send_evt(MODE_REPORT, NODE_W'(2), {PAGE_W'(1), OFF_W'(0)});
        send_evt(MODE_REPORT, NODE_W'(3), {PAGE_W'(0), OFF_MAX});
        send_evt(MODE_REPORT, NODE_W'(4), KEY_W'(1));
        send_evt(MODE_REPORT, NODE_W'(2), {PAGE_W'(0), OFF_MAX});
        send_evt(MODE_REPORT, NODE_W'(7), {PAGE_MAX, OFF_W'(0)});
        send_evt(MODE_CONNECT, NODE_W'(7), '0);
        send_evt(MODE_DISCONNECT, NODE_W'(0), '0);
        send_evt(MODE_DISCONNECT, NODE_W'(0), '0);
        send_evt(MODE_UNUSED, NODE_W'(0), KEY_MAX);
        send_evt(MODE_REPORT, NODE_W'(0), {PAGE_W'(5), OFF_W'(3)});
        set_nodes(4'd3);
        send_evt(MODE_CONNECT, NODE_W'(5), '0);
        send_evt(MODE_REPORT, NODE_W'(2), {PAGE_W'(2), OFF_W'(0)});
        set_nodes(4'd0);
        send_evt(MODE_CONNECT, NODE_W'(0), '0);
        send_evt(MODE_REPORT, NODE_W'(1), '0);
        set_nodes(4'd15);
        send_evt(MODE_REPORT, NODE_W'(6), KEY_MAX);
        send_evt(MODE_CONNECT, NODE_W'(6), '0);
        send_evt(MODE_DISCONNECT, NODE_W'(7), '0);

        for (int phase = 0; phase < 8; phase++) begin
            nodes = phase_nodes[phase];
            if (nodes == 0) nodes = $urandom_range(1, 15);
            set_nodes(CFG_W'(nodes));
            case (phase % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 59; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 59; end
                default: begin send_idle_pct = 7; stall_pct = 7; end
            endcase
            if (phase == 0) hold_len = HOLD_CYCLES;
            applied_n = 0;
            while (applied_n < ITEMS_PER_PHASE) begin
                send_random(applied);
                if (applied) applied_n++;
            end
        end

        evt_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
